// ----- hw/rtl/ctid_pkg.sv -----
// Shared types and constants for the compact tagged integer decoder.
`default_nettype none

package ctid_pkg;

    // Header byte fields.
    localparam logic [7:0] TAG_MASK = 8'h07;
    localparam logic [7:0] EXT_BIT  = 8'h08;
    localparam logic [7:0] WIDE_BIT = 8'h10;

    // A wide header with this top field announces a nested length term.
    localparam logic [2:0] NESTED_TOP = 3'd7;

    // A wide header with top field t carries t plus this many value bytes.
    localparam logic [3:0] COUNT_BIAS = 4'd2;

    // Default value byte limit; legal range is 2 to 8.
    localparam int unsigned MAX_VALUE_BYTES = 8;

    localparam int unsigned VALUE_W = 64;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_EXTRA  = 2'd1,
        PH_VALUE  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TRUNCATED = 2'd1,
        STATUS_TOO_LONG  = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]         tag;
        logic [VALUE_W-1:0] value;
        t_status            status;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/compact_tagged_integer_decoder_core.sv -----
// Top level of the compact tagged integer decoder.
`default_nettype none

// The decoder takes one byte of an encoded stream per transaction and
// produces one result transaction each time a term finishes. The low three
// bits of a header byte are the tag. With header bit 3 clear the value is the
// top four header bits; with bit 3 set and bit 4 clear it is the top three
// bits followed by one extra byte; with both set, a top field of 0 to 6 says
// that top plus two big-endian value bytes follow, and a top field of 7
// announces a nested length term, which ends the outer term as too long, or as
// truncated if it is cut short. A byte flagged as the last of the buffer that
// leaves a term unfinished yields a truncated result carrying the outer tag.
// Non-ok results carry a value of zero. Throughput is one byte per clock cycle
// while the input is not stalled: each byte needs only a header decode or a
// single shift-and-merge into the accumulator, done combinationally between
// the decoder state registers and the output stage, which captures the result
// as the byte that finished the term is accepted. A two-entry output stage
// (result register plus skid register) keeps the input stall a registered
// signal, so the input keeps taking bytes while one result waits to be taken.
module compact_tagged_integer_decoder_core #(
    parameter int unsigned MAX_VALUE_BYTES = ctid_pkg::MAX_VALUE_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Byte input channel.
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,

    // Result output channel.
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_term_tag,
    output logic [63:0]      o_term_value,
    output logic [1:0]       o_status
);

    // The accumulator only needs to hold a value that fits the byte limit;
    // longer values end as too long and report zero.
    localparam int unsigned ACC_W = 8 * MAX_VALUE_BYTES;
    localparam logic [3:0]  MAX_BYTES = 4'(MAX_VALUE_BYTES);

    // Decoder state.
    ctid_pkg::t_phase   r_phase,      n_phase;
    logic [2:0]         r_held_tag,   n_held_tag;
    logic               r_pending,    n_pending;
    logic [2:0]         r_high_bits,  n_high_bits;
    logic [ACC_W-1:0]   r_acc,        n_acc;
    logic [3:0]         r_bytes_left, n_bytes_left;

    // Output stage.
    logic               r_out_valid;
    logic               r_skid_valid;
    ctid_pkg::t_result  r_out;
    ctid_pkg::t_result  r_skid;

    logic               in_fire;
    logic               out_take;
    logic               res_valid;
    ctid_pkg::t_result  res;

    // Per-byte decode scratch.
    logic               do_emit;
    ctid_pkg::t_status  emit_status;
    logic [ctid_pkg::VALUE_W-1:0] emit_value;
    logic [2:0]         hdr_top;
    logic [3:0]         hdr_count;
    logic [ACC_W-1:0]   acc_shift;

    // The input stalls only when the skid register is full, which is a
    // registered condition.
    assign o_stall  = r_skid_valid;
    assign in_fire  = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;

    assign hdr_top   = i_data_byte[7:5];
    assign hdr_count = {1'b0, hdr_top} + ctid_pkg::COUNT_BIAS;
    assign acc_shift = {r_acc[ACC_W-9:0], i_data_byte};

    always_comb begin
        n_phase      = r_phase;
        n_held_tag   = r_held_tag;
        n_pending    = r_pending;
        n_high_bits  = r_high_bits;
        n_acc        = r_acc;
        n_bytes_left = r_bytes_left;
        do_emit      = 1'b0;
        emit_status  = ctid_pkg::STATUS_OK;
        emit_value   = '0;

        unique case (r_phase)
            ctid_pkg::PH_EXTRA: begin
                // Second byte of a two-byte term finishes it.
                do_emit    = 1'b1;
                emit_value = ctid_pkg::VALUE_W'({r_high_bits, i_data_byte});
            end
            ctid_pkg::PH_VALUE: begin
                n_acc = acc_shift;
                if (r_bytes_left <= 4'd1) begin
                    do_emit    = 1'b1;
                    emit_value = ctid_pkg::VALUE_W'(acc_shift);
                end else begin
                    n_bytes_left = r_bytes_left - 4'd1;
                    if (i_last_byte) begin
                        do_emit     = 1'b1;
                        emit_status = ctid_pkg::STATUS_TRUNCATED;
                    end
                end
            end
            default: begin
                // Header byte. Inside a nested length term the outer tag stays.
                if (!r_pending) begin
                    n_held_tag = i_data_byte[2:0] & ctid_pkg::TAG_MASK[2:0];
                end
                if ((i_data_byte & ctid_pkg::EXT_BIT) == 8'h00) begin
                    do_emit    = 1'b1;
                    emit_value = ctid_pkg::VALUE_W'(i_data_byte[7:4]);
                end else if ((i_data_byte & ctid_pkg::WIDE_BIT) == 8'h00) begin
                    if (i_last_byte) begin
                        do_emit     = 1'b1;
                        emit_status = ctid_pkg::STATUS_TRUNCATED;
                    end else begin
                        n_high_bits = hdr_top;
                        n_phase     = ctid_pkg::PH_EXTRA;
                    end
                end else if (hdr_top == ctid_pkg::NESTED_TOP) begin
                    // The nested term's count always exceeds the byte limit.
                    if (i_last_byte) begin
                        do_emit     = 1'b1;
                        emit_status = ctid_pkg::STATUS_TRUNCATED;
                    end else begin
                        n_pending = 1'b1;
                        n_phase   = ctid_pkg::PH_HEADER;
                    end
                end else begin
                    if (i_last_byte) begin
                        do_emit     = 1'b1;
                        emit_status = ctid_pkg::STATUS_TRUNCATED;
                    end else begin
                        if (hdr_count > MAX_BYTES) begin
                            n_pending = 1'b1;
                        end
                        n_acc        = '0;
                        n_bytes_left = hdr_count;
                        n_phase      = ctid_pkg::PH_VALUE;
                    end
                end
            end
        endcase

        // A finished term under a pending nested length reports too long.
        if (do_emit && emit_status == ctid_pkg::STATUS_OK && r_pending) begin
            emit_status = ctid_pkg::STATUS_TOO_LONG;
            emit_value  = '0;
        end

        res_valid  = do_emit;
        res.tag    = n_held_tag;
        res.value  = emit_value;
        res.status = emit_status;

        // Any result returns the decoder to a clean header state.
        if (do_emit) begin
            n_phase      = ctid_pkg::PH_HEADER;
            n_pending    = 1'b0;
            n_high_bits  = '0;
            n_acc        = '0;
            n_bytes_left = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ctid_pkg::PH_HEADER;
            r_held_tag   <= '0;
            r_pending    <= 1'b0;
            r_high_bits  <= '0;
            r_acc        <= '0;
            r_bytes_left <= '0;
        end else if (in_fire) begin
            r_phase      <= n_phase;
            r_held_tag   <= n_held_tag;
            r_pending    <= n_pending;
            r_high_bits  <= n_high_bits;
            r_acc        <= n_acc;
            r_bytes_left <= n_bytes_left;
        end
    end

    // Output stage control. New results enter only while the skid register
    // is empty, since the input is stalled otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire && res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_fire && res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_term_tag   = r_out.tag;
    assign o_term_value = r_out.value;
    assign o_status     = r_out.status;

    // The skid register only fills behind a held result.
    a_skid_behind_out: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid
    ) else $error("skid register full while result register empty");

    // Error results never carry a value.
    a_error_value_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ctid_pkg::STATUS_OK) |-> (o_term_value == 64'd0)
    ) else $error("error result with nonzero value");

    // While collecting value bytes the count stays between one and the largest wide-header count.
    a_value_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ctid_pkg::PH_VALUE) |->
            (r_bytes_left != 4'd0 && r_bytes_left <= ctid_pkg::COUNT_BIAS + 4'd6)
    ) else $error("value byte count out of range");

    // Emitting a result leaves the decoder at a clean header.
    a_emit_clears: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && res_valid) |=> (r_phase == ctid_pkg::PH_HEADER && !r_pending)
    ) else $error("decoder state not cleared after a result");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the compact tagged integer decoder core.
`timescale 1ns / 1ps

module tb;
    import ctid_pkg::*;

    localparam int MAXB           = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PLANNED_BYTES  = 850;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         gap;
        bit         drain;
    } byte_item_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_term_tag;
    logic [63:0] o_term_value;
    logic [1:0]  o_status;

    compact_tagged_integer_decoder_core #(
        .MAX_VALUE_BYTES(MAXB)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_term_tag(o_term_tag),
        .o_term_value(o_term_value),
        .o_status(o_status)
    );

    always #5 i_clk = ~i_clk;

    // Bytes waiting to be sent, and terms the decoder still owes us.
    byte_item_t pending_q[$];
    t_result    term_q[$];

    // Shadow copy of the decoder state.
    t_phase      dec_phase  = PH_HEADER;
    logic [2:0]  dec_tag    = 3'd0;
    logic        dec_long   = 1'b0;
    logic [2:0]  dec_high   = 3'd0;
    logic [63:0] dec_acc    = 64'd0;
    logic [3:0]  dec_left   = 4'd0;

    int err_cnt     = 0;
    int bytes_total = 0;
    int bytes_taken = 0;
    int result_cnt  = 0;
    int ok_cnt      = 0;
    int trunc_cnt   = 0;
    int long_cnt    = 0;
    int idle_cycles = 0;
    int tx_mode     = 1;
    int rx_mode     = 1;
    int rx_wait     = 0;
    int hold_cnt    = 0;
    bit staged      = 0;
    bit in_taken    = 0;
    bit out_taken   = 0;

    byte_item_t cur_item;
    t_result    want;

    // Mode 0 never idles, mode 1 idles at random, mode 2 idles now and then.
    function automatic int draw_gap(input int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 18);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endfunction

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic emit_term(input logic [63:0] value, input t_status st);
        t_result r;
        r.tag    = dec_tag;
        r.value  = value;
        r.status = st;
        term_q.push_back(r);
        dec_phase = PH_HEADER;
        dec_long  = 1'b0;
        dec_high  = 3'd0;
        dec_acc   = 64'd0;
        dec_left  = 4'd0;
    endtask

    // A term that ends while a nested length is pending is always too long.
    task automatic finish_term(input logic [63:0] value);
        if (dec_long)
            emit_term(64'd0, STATUS_TOO_LONG);
        else
            emit_term(value, STATUS_OK);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [3:0] nbytes;
        case (dec_phase)
            PH_EXTRA: begin
                finish_term({53'd0, dec_high, b});
            end
            PH_VALUE: begin
                dec_acc = {dec_acc[55:0], b};
                if (dec_left <= 4'd1) begin
                    finish_term(dec_acc);
                end else begin
                    dec_left = dec_left - 4'd1;
                    if (last)
                        emit_term(64'd0, STATUS_TRUNCATED);
                end
            end
            default: begin
                // Headers inside a nested length term keep the outer tag.
                if (!dec_long)
                    dec_tag = b[2:0];
                if ((b & EXT_BIT) == 8'd0) begin
                    finish_term({60'd0, b[7:4]});
                end else if ((b & WIDE_BIT) == 8'd0) begin
                    if (last) begin
                        emit_term(64'd0, STATUS_TRUNCATED);
                    end else begin
                        dec_high  = b[7:5];
                        dec_phase = PH_EXTRA;
                    end
                end else if (b[7:5] == NESTED_TOP) begin
                    if (last)
                        emit_term(64'd0, STATUS_TRUNCATED);
                    else
                        dec_long = 1'b1;
                end else begin
                    nbytes = {1'b0, b[7:5]} + COUNT_BIAS;
                    if (nbytes > MAXB)
                        dec_long = 1'b1;
                    if (last) begin
                        emit_term(64'd0, STATUS_TRUNCATED);
                    end else begin
                        dec_acc   = 64'd0;
                        dec_left  = nbytes;
                        dec_phase = PH_VALUE;
                    end
                end
            end
        endcase
    endtask

    // Every so often a byte waits until all owed terms have come back.
    task automatic add_byte(input logic [7:0] b, input logic last, input bit pause);
        byte_item_t it;
        it.data  = b;
        it.last  = last;
        it.gap   = draw_gap(tx_mode);
        it.drain = pause || (pending_q.size() % 150 == 149);
        pending_q.push_back(it);
    endtask

    // One well-formed term with random content, sometimes cut short.
    task automatic add_random_term();
        logic [7:0] bq[$];
        int nest;
        int kind;
        int top;
        int cut;
        nest = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
        repeat (nest)
            bq.push_back({NESTED_TOP, 2'b11, 3'($urandom_range(0, 7))});
        kind = $urandom_range(0, 2);
        case (kind)
            0: begin
                bq.push_back({4'($urandom_range(0, 15)), 1'b0, 3'($urandom_range(0, 7))});
            end
            1: begin
                bq.push_back({3'($urandom_range(0, 7)), 2'b01, 3'($urandom_range(0, 7))});
                bq.push_back(rand_byte());
            end
            default: begin
                top = $urandom_range(0, 6);
                bq.push_back({3'(top), 2'b11, 3'($urandom_range(0, 7))});
                repeat (top + 2)
                    bq.push_back(rand_byte());
            end
        endcase
        if (bq.size() > 1 && $urandom_range(0, 9) == 0) begin
            cut = $urandom_range(0, bq.size() - 2);
            for (int i = 0; i <= cut; i++)
                add_byte(bq[i], i == cut, 1'b0);
        end else begin
            for (int i = 0; i < bq.size(); i++)
                add_byte(bq[i], (i == bq.size() - 1) && ($urandom_range(0, 7) == 0), 1'b0);
        end
    endtask

    // Byte driver: a held transaction stays put until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !in_taken)) begin
            if (!staged && pending_q.size() != 0) begin
                cur_item = pending_q.pop_front();
                staged   = 1;
                hold_cnt = cur_item.gap;
            end
            if (staged && hold_cnt == 0 && (!cur_item.drain || term_q.size() == 0)) begin
                i_valid     <= 1'b1;
                i_data_byte <= cur_item.data;
                i_last_byte <= cur_item.last;
                staged = 0;
            end else begin
                i_valid <= 1'b0;
                if (staged && hold_cnt != 0)
                    hold_cnt--;
            end
        end
    end

    // Result receiver: stalls for a drawn number of cycles after each result.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (out_taken) begin
                if (result_cnt % 37 == 0)
                    rx_mode = $urandom_range(0, 2);
                rx_wait = draw_gap(rx_mode);
            end
            if (rx_wait != 0) begin
                i_stall <= 1'b1;
                rx_wait--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Monitor: check results first, then predict from the accepted byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= i_valid && !o_stall;
            out_taken <= o_valid && !i_stall;
            if (o_valid && !i_stall) begin
                result_cnt++;
                if (term_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("tb: unexpected result tag=%0d value=%h status=%0d",
                                 o_term_tag, o_term_value, o_status);
                end else begin
                    want = term_q.pop_front();
                    if (o_term_tag !== want.tag || o_term_value !== want.value ||
                        o_status !== want.status) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("tb: mismatch exp tag=%0d value=%h status=%0d,",
                                     want.tag, want.value, want.status,
                                     " got tag=%0d value=%h status=%0d",
                                     o_term_tag, o_term_value, o_status);
                    end
                    case (want.status)
                        STATUS_OK:        ok_cnt++;
                        STATUS_TRUNCATED: trunc_cnt++;
                        default:          long_cnt++;
                    endcase
                end
            end
            if (i_valid && !o_stall) begin
                decode_byte(i_data_byte, i_last_byte);
                bytes_taken++;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        // Directed terms: value extremes, every header form, nesting and truncation.
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hF7, 1'b1, 1'b0);    // last flag on a finishing byte
        add_byte(8'hE8, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hDF, 1'b0, 1'b0);    // eight value bytes, all ones
        repeat (8)
            add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h18, 1'b0, 1'b0);
        add_byte(8'hAB, 1'b0, 1'b0);
        add_byte(8'hCD, 1'b0, 1'b0);
        add_byte(8'hF9, 1'b0, 1'b1);    // nested length, sent after a full drain
        add_byte(8'h25, 1'b0, 1'b0);
        add_byte(8'hFA, 1'b0, 1'b0);    // nested inside nested keeps the outer tag
        add_byte(8'hFB, 1'b0, 1'b0);
        add_byte(8'h38, 1'b0, 1'b0);
        add_byte(8'h12, 1'b0, 1'b0);
        add_byte(8'h08, 1'b1, 1'b0);    // cut one byte short of a three-byte value
        add_byte(8'hFE, 1'b0, 1'b0);    // cut inside value bytes while nested
        add_byte(8'h19, 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hF8, 1'b1, 1'b0);    // cut on a nested length header

        while (pending_q.size() < PLANNED_BYTES) begin
            if ($urandom_range(0, 29) == 0)
                tx_mode = $urandom_range(0, 2);
            if ($urandom_range(0, 11) == 0)
                add_byte(rand_byte(), $urandom_range(0, 3) == 0, 1'b0);
            else
                add_random_term();
        end
        bytes_total = pending_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (bytes_taken == bytes_total);
        wait (term_q.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("tb: %0d bytes sent, %0d terms checked", bytes_taken, result_cnt);
        $display("tb: %0d ok, %0d truncated, %0d too long, %0d errors",
                 ok_cnt, trunc_cnt, long_cnt, err_cnt);
        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ctid_pkg.sv
hw/rtl/compact_tagged_integer_decoder_core.sv
tb/tb.sv
